// ===== sv/owh_pkg.sv =====
// ----------------------------------------------------------------------------
// owh_pkg
// shared constants and types of the offline window history block
// ----------------------------------------------------------------------------
package owh_pkg;

    localparam int WEEK_SLOTS_DEF = 2016;
    localparam int DAY_SLOTS_DEF  = 288;
    localparam int HOUR_SLOTS_DEF = 12;

    localparam int NUM_BINS = 24;
    localparam int BIN_MAX  = 255;

    localparam int COUNT_W     = 8;
    localparam int TOTAL_W     = 9;
    localparam int OFF_HOUR_W  = 4;
    localparam int OFF_DAY_W   = 9;
    localparam int OFF_WEEK_W  = 11;
    localparam int BIN_INDEX_W = 5;
    localparam int BIN_VALUE_W = 8;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 1;
    localparam int RESULT_W    = OFF_HOUR_W + OFF_DAY_W + OFF_WEEK_W + BIN_INDEX_W
                                 + BIN_VALUE_W;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic OP_RECORD    = 1'b0;
    localparam logic OP_HISTOGRAM = 1'b1;

    typedef struct packed {
        logic [BIN_VALUE_W-1:0] bin_value;
        logic [BIN_INDEX_W-1:0] bin_index;
        logic [OFF_WEEK_W-1:0]  offline_week;
        logic [OFF_DAY_W-1:0]   offline_day;
        logic [OFF_HOUR_W-1:0]  offline_hour;
    } result_t;

endpackage

// ===== sv/owh_ram.sv =====
// ----------------------------------------------------------------------------
// owh_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module owh_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/offline_window_history.sv =====
// ----------------------------------------------------------------------------
// offline_window_history
// week ring of offline flags and day ring of device totals, with sliding
// offline counts after each record and a 24 bin hourly histogram on request
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: operation; tdata: wifi, ble
//  m_axis    out  m_axis_tvalid/tready       tdata: counts, bin; tlast: last
//
//  after reset a clearing pass writes both rings, with s_axis_tready low
//  record: the result is set by three reads in states REC_A to REC_C through the
//  single read port of the offline ring before the write back in REC_UPD
//  histogram: one total read a cycle while a bin is summed, then a sum register
//  and a reciprocal multiply per bin; after either kind the sequencer returns
//  to idle before it takes the next request
//  one request at a time; the result register lets the next request start
//  while a result waits, a stalled m_axis holds the sequencer at its push
// ----------------------------------------------------------------------------
module offline_window_history #(
    parameter int WEEK_SLOTS = owh_pkg::WEEK_SLOTS_DEF,
    parameter int DAY_SLOTS  = owh_pkg::DAY_SLOTS_DEF,
    parameter int HOUR_SLOTS = owh_pkg::HOUR_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // wifi_count [7:0], ble_count [15:8]
    input  logic [owh_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // operation [0]
    input  logic [owh_pkg::IN_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // offline_hour [3:0], offline_day [12:4], offline_week [23:13],
    // bin_index [28:24], bin_value [36:29], zero [39:37]
    output logic [owh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);

    localparam int WS_W   = $clog2(WEEK_SLOTS);
    localparam int DS_W   = $clog2(DAY_SLOTS);
    localparam int CLR_N  = (WEEK_SLOTS > DAY_SLOTS) ? WEEK_SLOTS : DAY_SLOTS;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int NH     = (HOUR_SLOTS < WEEK_SLOTS) ? HOUR_SLOTS : WEEK_SLOTS;
    localparam int ND     = (DAY_SLOTS < WEEK_SLOTS) ? DAY_SLOTS : WEEK_SLOTS;
    localparam int BACK   = (owh_pkg::NUM_BINS * HOUR_SLOTS) % WEEK_SLOTS;
    localparam int BACK_D = BACK % DAY_SLOTS;
    localparam int FWD_D  = (WEEK_SLOTS - BACK) % DAY_SLOTS;
    localparam int SUMW   = owh_pkg::TOTAL_W + $clog2(HOUR_SLOTS);
    localparam int HC_W   = $clog2(HOUR_SLOTS + 1);
    localparam int DIV_SH = SUMW + $clog2(HOUR_SLOTS);
    localparam int PROD_W = 2 * SUMW + 1;

    localparam logic [SUMW:0]   DIV_RCP = (SUMW + 1)'((2 ** DIV_SH + HOUR_SLOTS - 1)
                                                      / HOUR_SLOTS);
    localparam logic [SUMW-1:0] SAT_SUM = SUMW'(HOUR_SLOTS * (2 ** owh_pkg::BIN_VALUE_W));

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REC_A,
        ST_REC_B,
        ST_REC_C,
        ST_REC_D,
        ST_REC_UPD,
        ST_H_SUM,
        ST_H_LAST,
        ST_H_DIV,
        ST_H_OUT
    } state_t;

    state_t state_reg;

    logic [CLR_W-1:0]                   clr_reg;
    logic [WS_W-1:0]                    ws_reg;
    logic [DS_W-1:0]                    ws_day_reg;
    logic [owh_pkg::OFF_HOUR_W-1:0]     cnt_hour_reg;
    logic [owh_pkg::OFF_DAY_W-1:0]      cnt_day_reg;
    logic [owh_pkg::OFF_WEEK_W-1:0]     cnt_week_reg;
    logic [owh_pkg::COUNT_W-1:0]        wifi_reg;
    logic [owh_pkg::COUNT_W-1:0]        ble_reg;
    logic                               old_hour_reg;
    logic                               old_day_reg;
    logic                               old_week_reg;
    logic [WS_W-1:0]                    p_reg;
    logic [DS_W-1:0]                    q_reg;
    logic [HC_W-1:0]                    s_reg;
    logic                               rd_pend_reg;
    logic [SUMW-1:0]                    sum_reg;
    logic [SUMW-1:0]                    bin_sum_reg;
    logic [owh_pkg::BIN_VALUE_W-1:0]    quo_reg;
    logic                               sat_reg;
    logic [owh_pkg::BIN_INDEX_W-1:0]    bin_reg;
    logic                               out_valid_reg;
    owh_pkg::result_t                   out_reg;
    logic                               out_last_reg;

    logic                               week_we;
    logic [WS_W-1:0]                    week_waddr;
    logic                               week_wdata;
    logic [WS_W-1:0]                    week_raddr;
    logic                               week_rdata;
    logic                               day_we;
    logic [DS_W-1:0]                    day_waddr;
    logic [owh_pkg::TOTAL_W-1:0]        day_wdata;
    logic [owh_pkg::TOTAL_W-1:0]        day_rdata;

    logic [WS_W-1:0]                    hour_addr;
    logic [WS_W-1:0]                    dwin_addr;
    logic [WS_W-1:0]                    p_start;
    logic [DS_W-1:0]                    q_start;
    logic [DS_W:0]                      q_fwd;
    logic                               offline_new;
    logic [owh_pkg::TOTAL_W-1:0]        total_new;
    logic [SUMW-1:0]                    sum_fin;
    logic [PROD_W-1:0]                  div_prod;
    logic                               out_free;
    logic                               out_push;
    logic                               in_accept;
    logic                               clr_last;
    logic                               ws_wrap;
    logic                               bin_last;
    logic [owh_pkg::BIN_VALUE_W-1:0]    bin_value;

    // ring position arithmetic
    always_comb
    begin
        if ({1'b0, ws_reg} >= (WS_W + 1)'(NH))
        begin
            hour_addr = WS_W'({1'b0, ws_reg} - (WS_W + 1)'(NH));
        end
        else
        begin
            hour_addr = WS_W'({1'b0, ws_reg} + (WS_W + 1)'(WEEK_SLOTS - NH));
        end

        if ({1'b0, ws_reg} >= (WS_W + 1)'(ND))
        begin
            dwin_addr = WS_W'({1'b0, ws_reg} - (WS_W + 1)'(ND));
        end
        else
        begin
            dwin_addr = WS_W'({1'b0, ws_reg} + (WS_W + 1)'(WEEK_SLOTS - ND));
        end

        q_fwd = {1'b0, ws_day_reg} + (DS_W + 1)'(FWD_D);
        if ({1'b0, ws_reg} >= (WS_W + 1)'(BACK))
        begin
            p_start = WS_W'({1'b0, ws_reg} - (WS_W + 1)'(BACK));
            if ({1'b0, ws_day_reg} >= (DS_W + 1)'(BACK_D))
            begin
                q_start = DS_W'({1'b0, ws_day_reg} - (DS_W + 1)'(BACK_D));
            end
            else
            begin
                q_start = DS_W'({1'b0, ws_day_reg} + (DS_W + 1)'(DAY_SLOTS - BACK_D));
            end
        end
        else
        begin
            p_start = WS_W'({1'b0, ws_reg} + (WS_W + 1)'(WEEK_SLOTS - BACK));
            if (q_fwd >= (DS_W + 1)'(DAY_SLOTS))
            begin
                q_start = DS_W'(q_fwd - (DS_W + 1)'(DAY_SLOTS));
            end
            else
            begin
                q_start = DS_W'(q_fwd);
            end
        end
    end

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_push      = ((state_reg == ST_REC_UPD) || (state_reg == ST_H_OUT)) && out_free;
    assign clr_last      = (clr_reg == CLR_W'(CLR_N - 1));
    assign ws_wrap       = (ws_reg == WS_W'(WEEK_SLOTS - 1));
    assign bin_last      = (bin_reg == owh_pkg::BIN_INDEX_W'(owh_pkg::NUM_BINS - 1));
    assign offline_new   = (wifi_reg == '0) && (ble_reg == '0);
    assign total_new     = {1'b0, wifi_reg} + {1'b0, ble_reg};
    assign sum_fin       = sum_reg + SUMW'(day_rdata);
    assign div_prod      = PROD_W'(bin_sum_reg) * PROD_W'(DIV_RCP);
    assign bin_value     = sat_reg ? owh_pkg::BIN_VALUE_W'(owh_pkg::BIN_MAX) : quo_reg;

    // memory ports
    always_comb
    begin
        week_we    = 1'b0;
        week_waddr = ws_reg;
        week_wdata = offline_new;
        day_we     = 1'b0;
        day_waddr  = ws_day_reg;
        day_wdata  = total_new;
        if (state_reg == ST_CLEAR)
        begin
            week_we    = {1'b0, clr_reg} < (CLR_W + 1)'(WEEK_SLOTS);
            week_waddr = clr_reg[WS_W-1:0];
            week_wdata = 1'b0;
            day_we     = {1'b0, clr_reg} < (CLR_W + 1)'(DAY_SLOTS);
            day_waddr  = clr_reg[DS_W-1:0];
            day_wdata  = '0;
        end
        else if (state_reg == ST_REC_UPD && out_free)
        begin
            week_we = 1'b1;
            day_we  = 1'b1;
        end

        case (state_reg)
            ST_REC_A: week_raddr = hour_addr;
            ST_REC_B: week_raddr = dwin_addr;
            default:  week_raddr = ws_reg;
        endcase
    end

    owh_ram #(
        .WIDTH (1),
        .DEPTH (WEEK_SLOTS)
    ) u_offline_ram (
        .clk   (clk),
        .we    (week_we),
        .waddr (week_waddr),
        .wdata (week_wdata),
        .raddr (week_raddr),
        .rdata (week_rdata)
    );

    owh_ram #(
        .WIDTH (owh_pkg::TOTAL_W),
        .DEPTH (DAY_SLOTS)
    ) u_total_ram (
        .clk   (clk),
        .we    (day_we),
        .waddr (day_waddr),
        .wdata (day_wdata),
        .raddr (q_reg),
        .rdata (day_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            ws_reg        <= '0;
            ws_day_reg    <= '0;
            cnt_hour_reg  <= '0;
            cnt_day_reg   <= '0;
            cnt_week_reg  <= '0;
            wifi_reg      <= '0;
            ble_reg       <= '0;
            old_hour_reg  <= 1'b0;
            old_day_reg   <= 1'b0;
            old_week_reg  <= 1'b0;
            p_reg         <= '0;
            q_reg         <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            s_reg         <= '0;
            sum_reg       <= '0;
            bin_sum_reg   <= '0;
            quo_reg       <= '0;
            sat_reg       <= 1'b0;
            bin_reg       <= '0;
            out_reg       <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        wifi_reg    <= s_axis_tdata[owh_pkg::COUNT_W-1:0];
                        ble_reg     <= s_axis_tdata[2*owh_pkg::COUNT_W-1:owh_pkg::COUNT_W];
                        p_reg       <= p_start;
                        q_reg       <= q_start;
                        s_reg       <= '0;
                        sum_reg     <= '0;
                        rd_pend_reg <= 1'b0;
                        bin_reg     <= '0;
                        if (s_axis_tuser[0] == owh_pkg::OP_HISTOGRAM)
                        begin
                            state_reg <= ST_H_SUM;
                        end
                        else
                        begin
                            state_reg <= ST_REC_A;
                        end
                    end
                end

                ST_REC_A:
                begin
                    state_reg <= ST_REC_B;
                end

                ST_REC_B:
                begin
                    old_hour_reg <= week_rdata;
                    state_reg    <= ST_REC_C;
                end

                ST_REC_C:
                begin
                    old_day_reg <= week_rdata;
                    state_reg   <= ST_REC_D;
                end

                ST_REC_D:
                begin
                    old_week_reg <= week_rdata;
                    state_reg    <= ST_REC_UPD;
                end

                ST_REC_UPD:
                begin
                    if (out_free)
                    begin
                        cnt_hour_reg <= cnt_hour_reg
                                        + owh_pkg::OFF_HOUR_W'(offline_new)
                                        - owh_pkg::OFF_HOUR_W'(old_hour_reg);
                        cnt_day_reg  <= cnt_day_reg
                                        + owh_pkg::OFF_DAY_W'(offline_new)
                                        - owh_pkg::OFF_DAY_W'(old_day_reg);
                        cnt_week_reg <= cnt_week_reg
                                        + owh_pkg::OFF_WEEK_W'(offline_new)
                                        - owh_pkg::OFF_WEEK_W'(old_week_reg);
                        out_reg.offline_hour <= cnt_hour_reg
                                        + owh_pkg::OFF_HOUR_W'(offline_new)
                                        - owh_pkg::OFF_HOUR_W'(old_hour_reg);
                        out_reg.offline_day  <= cnt_day_reg
                                        + owh_pkg::OFF_DAY_W'(offline_new)
                                        - owh_pkg::OFF_DAY_W'(old_day_reg);
                        out_reg.offline_week <= cnt_week_reg
                                        + owh_pkg::OFF_WEEK_W'(offline_new)
                                        - owh_pkg::OFF_WEEK_W'(old_week_reg);
                        out_reg.bin_index <= '0;
                        out_reg.bin_value <= '0;
                        out_last_reg      <= 1'b1;
                        if (ws_wrap)
                        begin
                            ws_reg     <= '0;
                            ws_day_reg <= '0;
                        end
                        else
                        begin
                            ws_reg <= ws_reg + 1'b1;
                            if (ws_day_reg == DS_W'(DAY_SLOTS - 1))
                            begin
                                ws_day_reg <= '0;
                            end
                            else
                            begin
                                ws_day_reg <= ws_day_reg + 1'b1;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                ST_H_SUM:
                begin
                    // one total read issued a cycle, each summed in the cycle after its read
                    if (rd_pend_reg)
                    begin
                        sum_reg <= sum_fin;
                    end
                    rd_pend_reg <= 1'b1;
                    if (p_reg == WS_W'(WEEK_SLOTS - 1))
                    begin
                        p_reg <= '0;
                        q_reg <= '0;
                    end
                    else
                    begin
                        p_reg <= p_reg + 1'b1;
                        if (q_reg == DS_W'(DAY_SLOTS - 1))
                        begin
                            q_reg <= '0;
                        end
                        else
                        begin
                            q_reg <= q_reg + 1'b1;
                        end
                    end
                    if (s_reg == HC_W'(HOUR_SLOTS - 1))
                    begin
                        state_reg <= ST_H_LAST;
                    end
                    else
                    begin
                        s_reg <= s_reg + 1'b1;
                    end
                end

                ST_H_LAST:
                begin
                    sat_reg     <= (sum_fin >= SAT_SUM);
                    bin_sum_reg <= sum_fin;
                    state_reg   <= ST_H_DIV;
                end

                ST_H_DIV:
                begin
                    // division by the hour length as a reciprocal multiply
                    quo_reg   <= div_prod[DIV_SH +: owh_pkg::BIN_VALUE_W];
                    state_reg <= ST_H_OUT;
                end

                ST_H_OUT:
                begin
                    if (out_free)
                    begin
                        out_reg.offline_hour <= cnt_hour_reg;
                        out_reg.offline_day  <= cnt_day_reg;
                        out_reg.offline_week <= cnt_week_reg;
                        out_reg.bin_index    <= bin_reg;
                        out_reg.bin_value    <= bin_value;
                        out_last_reg         <= bin_last;
                        bin_reg              <= bin_reg + 1'b1;
                        s_reg                <= '0;
                        sum_reg              <= '0;
                        rd_pend_reg          <= 1'b0;
                        if (bin_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_H_SUM;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(owh_pkg::OUT_TDATA_W - owh_pkg::RESULT_W)'(0), out_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_slot_pair: assert property (@(posedge clk) disable iff (!rst_n)
        ws_reg == '0 |-> ws_day_reg == '0)
        else $error("day slot out of step with week slot");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, ws_reg} < (WS_W + 1)'(WEEK_SLOTS)) &&
        ({1'b0, ws_day_reg} < (DS_W + 1)'(DAY_SLOTS)))
        else $error("ring slot beyond ring length");

    a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
        (out_reg.bin_index != owh_pkg::BIN_INDEX_W'(owh_pkg::NUM_BINS - 1)))
        else $error("final histogram bin without last flag");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_H_DIV) |-> !s_axis_tready)
        else $error("request taken while busy");
`endif

endmodule

// ===== tb/tb_offline_window_history.sv =====
// ----------------------------------------------------------------------------
// tb_offline_window_history
// self-checking bench for the offline window history block: scan records and
// histogram reads go in over s_axis, every result on m_axis is checked field
// by field against a behavioural model of both rings, with random idling on
// either side and a long output hold-off
// ----------------------------------------------------------------------------
module tb_offline_window_history;

    import owh_pkg::*;

    localparam int WEEK = WEEK_SLOTS_DEF;
    localparam int DAY  = DAY_SLOTS_DEF;
    localparam int HOUR = HOUR_SLOTS_DEF;

    localparam int STALL_LIMIT   = 8000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic    last;
        result_t fields;
    } scan_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // model of the block state
    bit                 offline_ring [WEEK];
    logic [TOTAL_W-1:0] total_ring [DAY];
    int unsigned        write_slot;
    logic [OFF_HOUR_W-1:0] hour_count;
    logic [OFF_DAY_W-1:0]  day_count;
    logic [OFF_WEEK_W-1:0] week_count;

    scan_result_t pending_results [$];

    int unsigned send_idle_pct   = 0;
    int unsigned ready_stall_pct = 0;
    int unsigned hold_left       = 0;
    int unsigned idle_cycles     = 0;
    int unsigned mismatches      = 0;

    always #5 clk = ~clk;

    offline_window_history i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------------
    // history model
    // ------------------------------------------------------------------------
    function automatic int unsigned offline_in_window(int unsigned span);
        int unsigned n;
        int unsigned pos;
        int unsigned cnt;
        n   = (span < WEEK) ? span : WEEK;
        pos = (write_slot + WEEK - n) % WEEK;
        cnt = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            cnt += offline_ring[pos];
            pos = (pos + 1) % WEEK;
        end
        return cnt;
    endfunction

    function automatic void push_result(int unsigned bin, int unsigned value, logic last);
        scan_result_t r;
        r.fields.offline_hour = hour_count;
        r.fields.offline_day  = day_count;
        r.fields.offline_week = week_count;
        r.fields.bin_index    = bin[BIN_INDEX_W-1:0];
        r.fields.bin_value    = value[BIN_VALUE_W-1:0];
        r.last                = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_request(logic op, logic [COUNT_W-1:0] wifi,
                                            logic [COUNT_W-1:0] ble);
        int unsigned back;
        int unsigned slot;
        int unsigned sum;
        int unsigned avg;
        if (op == OP_RECORD)
        begin
            offline_ring[write_slot]     = (wifi == 0 && ble == 0);
            total_ring[write_slot % DAY] = TOTAL_W'(wifi) + TOTAL_W'(ble);
            write_slot = (write_slot + 1) % WEEK;
            hour_count = OFF_HOUR_W'(offline_in_window(HOUR));
            day_count  = OFF_DAY_W'(offline_in_window(DAY));
            week_count = OFF_WEEK_W'(offline_in_window(WEEK));
            push_result(0, 0, 1'b1);
        end
        else
        begin
            for (int unsigned h = 0; h < NUM_BINS; h++)
            begin
                sum = 0;
                for (int unsigned s = 0; s < HOUR; s++)
                begin
                    back = ((NUM_BINS - h) * HOUR - s) % WEEK;
                    slot = (write_slot + WEEK - back) % WEEK;
                    sum += total_ring[slot % DAY];
                end
                avg = sum / HOUR;
                if (avg > BIN_MAX)
                    avg = BIN_MAX;
                push_result(h, avg, h == NUM_BINS - 1);
            end
        end
    endfunction

    function automatic void clear_history();
        foreach (offline_ring[i])
            offline_ring[i] = 1'b0;
        foreach (total_ring[i])
            total_ring[i] = '0;
        write_slot = 0;
        hour_count = '0;
        day_count  = '0;
        week_count = '0;
    endfunction

    // ------------------------------------------------------------------------
    // result checking and request capture
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, name, want,
                         got);
        end
    endfunction

    always @(posedge clk)
    begin
        scan_result_t want;
        scan_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.fields = m_axis_tdata[RESULT_W-1:0];
            got.last   = m_axis_tlast;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch at %0t: result with none expected, tdata %h",
                             $realtime, m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("offline_hour", 16'(want.fields.offline_hour),
                            16'(got.fields.offline_hour));
                check_field("offline_day", 16'(want.fields.offline_day),
                            16'(got.fields.offline_day));
                check_field("offline_week", 16'(want.fields.offline_week),
                            16'(got.fields.offline_week));
                check_field("bin_index", 16'(want.fields.bin_index),
                            16'(got.fields.bin_index));
                check_field("bin_value", 16'(want.fields.bin_value),
                            16'(got.fields.bin_value));
                check_field("last", 16'(want.last), 16'(got.last));
                check_field("tdata padding", '0, 16'(m_axis_tdata[OUT_TDATA_W-1:RESULT_W]));
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
            predict_request(s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[15:8]);
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL offline_window_history");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------
    task automatic send_request(logic op, logic [COUNT_W-1:0] wifi, logic [COUNT_W-1:0] ble);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ble, wifi};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [COUNT_W-1:0] random_count();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return COUNT_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_request(int unsigned histogram_pct);
        logic               op;
        logic [COUNT_W-1:0] wifi;
        logic [COUNT_W-1:0] ble;
        op = ($urandom_range(99) < histogram_pct) ? OP_HISTOGRAM : OP_RECORD;
        if ($urandom_range(3) == 0)
        begin
            wifi = '0;
            ble  = '0;
        end
        else
        begin
            wifi = random_count();
            ble  = random_count();
        end
        send_request(op, wifi, ble);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        // histogram over cleared rings, every bin wraps before the ring start
        send_request(OP_HISTOGRAM, '0, '0);
        send_request(OP_RECORD, 8'h00, 8'h00);
        send_request(OP_RECORD, 8'hff, 8'hff);
        send_request(OP_RECORD, 8'hff, 8'h00);
        send_request(OP_RECORD, 8'h00, 8'hff);
        send_request(OP_RECORD, 8'h01, 8'h00);
        send_request(OP_RECORD, 8'h00, 8'h01);
        send_request(OP_RECORD, 8'h80, 8'h40);
        send_request(OP_HISTOGRAM, 8'hff, 8'hff);
        // a full hour of maximum totals saturates the newest bin
        repeat (HOUR)
            send_request(OP_RECORD, 8'hff, 8'hff);
        send_request(OP_HISTOGRAM, 8'haa, 8'h55);
        wait_results_drained();
    endtask

    task automatic test_random_idling();
        int unsigned sender_pct [4]   = '{0, 77, 0, 35};
        int unsigned receiver_pct [4] = '{0, 0, 77, 35};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct   = sender_pct[p];
            ready_stall_pct = receiver_pct[p];
            repeat (30)
                send_random_request(10);
            wait_results_drained();
        end
    endtask

    task automatic test_output_hold_off();
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        repeat (10)
            send_random_request(0);
        send_request(OP_HISTOGRAM, '0, '0);
        wait_results_drained();
    endtask

    initial
    begin
        clear_history();
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_idling();
        test_output_hold_off();

        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("PASS offline_window_history");
        else
            $display("FAIL offline_window_history");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/owh_pkg.sv
sv/owh_ram.sv
sv/offline_window_history.sv
tb/tb_offline_window_history.sv
